// ===== rtl/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg: shared types and codes for the indexed shift list
// Operation, status and element kind codes, and the per-cell command.
// ----------------------------------------------------------------------------
package isl_pkg;

  // operation codes carried in in_tuser
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_POP    = 2'd3;

  // result status codes carried in out_tuser
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // element kind register values
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_INT    = 2'd1;
  localparam logic [1:0] KIND_FLOAT  = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;  // keeps all 32 bits, like integer

  localparam int ELEM_W = 32;

  // what every cell of the row does at the clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_cmd_t;

endpackage

// ===== rtl/isl_cell.sv =====
// ----------------------------------------------------------------------------
// isl_cell: one storage cell of the shift row
// Holds one element; loads the new value, its left or its right neighbor.
// ----------------------------------------------------------------------------
module isl_cell #(
  parameter int IDX = 0,
  parameter int PW  = 8
) (
  input  logic                         clk,
  input  isl_pkg::cell_cmd_t           cmd,
  input  logic [PW-1:0]                pos,
  input  logic [isl_pkg::ELEM_W-1:0]   wr_val,
  input  logic [isl_pkg::ELEM_W-1:0]   left_data,
  input  logic [isl_pkg::ELEM_W-1:0]   right_data,
  output logic [isl_pkg::ELEM_W-1:0]   data
);

  logic [isl_pkg::ELEM_W-1:0] data_r;
  logic [isl_pkg::ELEM_W-1:0] data_nxt;
  logic                       at_pos;
  logic                       past_pos;

  assign at_pos   = (pos == PW'(IDX));
  assign past_pos = (PW'(IDX) > pos);

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      isl_pkg::CELL_APPEND: begin
        if (at_pos) data_nxt = wr_val;
      end
      isl_pkg::CELL_INSERT: begin
        if (past_pos) data_nxt = left_data;
        else if (at_pos) data_nxt = wr_val;
      end
      isl_pkg::CELL_POP: begin
        if (past_pos || at_pos) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/indexed_shift_list_core.sv =====
// ----------------------------------------------------------------------------
// indexed_shift_list_core: bounded ordered list with insert and pop shifting
// A row of CAPACITY cells shifts right on insert and left on pop.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  in_      | slave     | tdata {index[39:32], value[31:0]}, tuser mode
//  out_     | master    | tdata {item_count[40:32], read_value[31:0]}, tuser status
//  cfg_     | write     | element_kind, written when cfg_wr_en is high
//
//  One operation per cycle unless the output stalls: every cell loads its new
//  value, left or right neighbor at the transfer edge, and the result lands in
//  the output register, so out_tvalid rises in the cycle after the transfer.
//  A result held by a low out_tready stalls the input; a result taken in the
//  same cycle lets the next input transfer through.
//  Synchronous active-low reset clears the count and the output valid; cell
//  contents are not reset and are never read before written.
// ----------------------------------------------------------------------------
module indexed_shift_list_core #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], index[39:32]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_value[31:0], item_count[40:32], zero fill
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data // element_kind
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = isl_pkg::ELEM_W;

  logic [1:0]    kind_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic [EW-1:0] rd_r;
  logic [EW-1:0] rd_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic [8:0]    cnt_out_r;

  logic             in_xfer;
  logic [1:0]       mode;
  logic [EW-1:0]    value;
  logic [7:0]       index;
  logic [31:0]      idx32;
  logic [31:0]      cnt32;
  logic [31:0]      cnt_nxt32;
  logic [EW-1:0]    wr_val;
  logic [EW-1:0]    sel_data;
  logic [EW-1:0]    cell_data [CAPACITY];
  isl_pkg::cell_cmd_t cmd;
  logic [PW-1:0]    pos;

  assign mode  = in_tuser;
  assign value = in_tdata[31:0];
  assign index = in_tdata[39:32];
  assign idx32 = 32'(index);
  assign cnt32 = 32'(count_r);

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign wr_val = (kind_r == isl_pkg::KIND_BYTE) ? {24'd0, value[7:0]} : value;

  // pick the element at index: one cell matches at most
  always_comb begin
    sel_data = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (idx32 == 32'(j)) sel_data = sel_data | cell_data[j];
    end
  end

  always_comb begin
    cmd.op     = isl_pkg::CELL_HOLD;
    pos        = PW'(index);
    count_nxt  = count_r;
    rd_nxt     = '0;
    status_nxt = isl_pkg::STATUS_OK;
    unique case (mode)
      isl_pkg::MODE_APPEND: begin
        pos = PW'(count_r);
        if (cnt32 >= 32'(CAPACITY)) begin
          status_nxt = isl_pkg::STATUS_FULL;
        end else begin
          cmd.op    = isl_pkg::CELL_APPEND;
          count_nxt = count_r + CW'(1);
        end
      end
      isl_pkg::MODE_INSERT: begin
        if (idx32 > cnt32) begin
          status_nxt = isl_pkg::STATUS_RANGE;
        end else if (cnt32 >= 32'(CAPACITY)) begin
          status_nxt = isl_pkg::STATUS_FULL;
        end else begin
          cmd.op    = isl_pkg::CELL_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      default: begin
        if (idx32 >= cnt32) begin
          status_nxt = isl_pkg::STATUS_RANGE;
        end else begin
          rd_nxt = (kind_r == isl_pkg::KIND_BYTE) ? {24'd0, sel_data[7:0]} : sel_data;
          if (mode == isl_pkg::MODE_POP) begin
            cmd.op    = isl_pkg::CELL_POP;
            count_nxt = count_r - CW'(1);
          end
        end
      end
    endcase
    if (!in_xfer) cmd.op = isl_pkg::CELL_HOLD;
  end

  assign cnt_nxt32 = 32'(count_nxt);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [EW-1:0] left_d;
      logic [EW-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_data[g+1];
      end
      isl_cell #(
        .IDX (g),
        .PW  (PW)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .pos        (pos),
        .wr_val     (wr_val),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= isl_pkg::KIND_INT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) kind_r <= cfg_wr_data;
      if (in_xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_r      <= rd_nxt;
      status_r  <= status_nxt;
      cnt_out_r <= cnt_nxt32[8:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, cnt_out_r, rd_r};
  assign out_tuser  = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt32 <= 32'(CAPACITY))
    else $error("element count above capacity");

  a_error_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && status_nxt != isl_pkg::STATUS_OK) |=> $stable(count_r))
    else $error("failed operation changed the count");

  a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != isl_pkg::STATUS_OK) |-> (rd_r == '0))
    else $error("error result carries a nonzero value");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && cmd.op == isl_pkg::CELL_POP) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not decrement the count");

endmodule

// ===== sim/tb_indexed_shift_list_core.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_shift_list_core: self-checking bench for the indexed shift list
// Drives append, insert, read and pop transfers under all element kinds, with
// random idle cycles on both channels. A scoreboard keeps its own copy of the
// list and checks every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_indexed_shift_list_core;

  localparam int LIST_DEPTH     = 256;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [8:0]  item_count;
  } list_result_t;

  // Mirror of the list contents; checks results in transfer order.
  class list_scoreboard;
    logic [31:0]  cells [LIST_DEPTH];
    int unsigned  held;
    logic [1:0]   kind;
    list_result_t expected_q [$];
    int unsigned  err_count;

    function new();
      held = 0;
      kind = isl_pkg::KIND_INT;
      err_count = 0;
    endfunction

    function void set_kind(logic [1:0] k);
      kind = k;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string what);
      $display("%0t ns list mismatch: %s", $time, what);
      err_count++;
    endtask

    function void note_input(logic [1:0] mode, logic [31:0] value, logic [7:0] index);
      logic [31:0]  mask;
      logic [31:0]  stored;
      list_result_t res;
      int           i;
      mask = (kind == isl_pkg::KIND_BYTE) ? 32'h0000_00FF : 32'hFFFF_FFFF;
      stored = value & mask;
      res.read_value = '0;
      res.status = isl_pkg::STATUS_OK;
      case (mode)
        isl_pkg::MODE_APPEND: begin
          if (held >= LIST_DEPTH) begin
            res.status = isl_pkg::STATUS_FULL;
          end else begin
            cells[held] = stored;
            held++;
          end
        end
        isl_pkg::MODE_INSERT: begin
          // range check wins over full check
          if (index > held) begin
            res.status = isl_pkg::STATUS_RANGE;
          end else if (held >= LIST_DEPTH) begin
            res.status = isl_pkg::STATUS_FULL;
          end else begin
            for (i = held; i > index; i--) cells[i] = cells[i-1];
            cells[index] = stored;
            held++;
          end
        end
        default: begin
          if (index >= held) begin
            res.status = isl_pkg::STATUS_RANGE;
          end else begin
            // byte kind masks on read too, whatever was stored before
            res.read_value = cells[index] & mask;
            if (mode == isl_pkg::MODE_POP) begin
              for (i = index; i + 1 < held; i++) cells[i] = cells[i+1];
              held--;
            end
          end
        end
      endcase
      res.item_count = held[8:0];
      expected_q.push_back(res);
    endfunction

    task check_result(logic [31:0] read_value, logic [1:0] status, logic [8:0] item_count);
      list_result_t exp_res;
      if (expected_q.size() == 0) begin
        report("result transfer with nothing outstanding");
      end else begin
        exp_res = expected_q.pop_front();
        if (read_value !== exp_res.read_value)
          report($sformatf("read_value %08h, expected %08h", read_value, exp_res.read_value));
        if (status !== exp_res.status)
          report($sformatf("status %0d, expected %0d", status, exp_res.status));
        if (item_count !== exp_res.item_count)
          report($sformatf("item_count %0d, expected %0d", item_count, exp_res.item_count));
      end
    endtask

    task flush_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // value[31:0], index[39:32]
  logic [1:0]  in_tuser;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // read_value[31:0], item_count[40:32], zero fill
  logic [1:0]  out_tuser;  // status[1:0]
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;

  logic        steady;      // no idle cycles on either side while set
  int unsigned quiet_cycles;

  list_scoreboard sb = new();

  indexed_shift_list_core #(
    .CAPACITY(LIST_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 36);
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_kind(cfg_wr_data);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[31:0], out_tuser, out_tdata[40:32]);
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser, in_tdata[31:0], in_tdata[39:32]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_op(input logic [1:0] mode, input logic [31:0] value,
                         input logic [7:0] index);
    while (!steady && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      in_tdata <= {8'($urandom_range(255)), 32'($urandom)};
      in_tuser <= 2'($urandom_range(3));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {index, value};
    in_tuser <= mode;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // kind changes only with the list idle
  task automatic write_kind(input logic [1:0] k);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= k;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // grow_pct: share of appends/inserts; read_pct: share of reads among the rest
  task automatic random_op(input int unsigned grow_pct, input int unsigned read_pct);
    logic [1:0]  mode;
    logic [31:0] value;
    logic [7:0]  index;
    int unsigned held;
    held = sb.held;
    value = $urandom;
    index = 8'($urandom_range(255));
    if ($urandom_range(99) < 8) begin
      mode = 2'($urandom_range(3));
    end else if ($urandom_range(99) < grow_pct) begin
      mode = ($urandom_range(1) == 0) ? isl_pkg::MODE_APPEND : isl_pkg::MODE_INSERT;
      if (mode == isl_pkg::MODE_INSERT)
        index = 8'($urandom_range((held > 255) ? 255 : held));
    end else begin
      mode = ($urandom_range(99) < read_pct) ? isl_pkg::MODE_READ : isl_pkg::MODE_POP;
      if (held != 0) index = 8'($urandom_range(held - 1));
    end
    send_op(mode, value, index);
  endtask

  initial begin
    int unsigned n;
    int unsigned extra;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = isl_pkg::MODE_APPEND;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = isl_pkg::KIND_BYTE;
    steady = 1'b0;
    quiet_cycles = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list errors, then build a few entries in integer kind
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd0);
    send_op(isl_pkg::MODE_POP,    32'h0,         8'd0);
    send_op(isl_pkg::MODE_INSERT, 32'h1111_1111, 8'd1);
    send_op(isl_pkg::MODE_INSERT, 32'h2222_2222, 8'd255);
    send_op(isl_pkg::MODE_INSERT, 32'h8000_0000, 8'd0);
    send_op(isl_pkg::MODE_APPEND, 32'hFFFF_FFFF, 8'd255);
    send_op(isl_pkg::MODE_APPEND, 32'h0000_0000, 8'd0);
    send_op(isl_pkg::MODE_INSERT, 32'h7FFF_FFFF, 8'd3);   // index equal to count
    send_op(isl_pkg::MODE_INSERT, 32'hA5A5_A5A5, 8'd1);
    send_op(isl_pkg::MODE_READ,   32'hFFFF_FFFF, 8'd0);
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd4);
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd5);   // one past the end
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd255);
    send_op(isl_pkg::MODE_POP,    32'h0,         8'd2);
    send_op(isl_pkg::MODE_POP,    32'h0,         8'd3);   // last entry
    send_op(isl_pkg::MODE_POP,    32'h0,         8'd4);   // out of range
    // byte kind: store masked, read masked, wide entries kept
    write_kind(isl_pkg::KIND_BYTE);
    send_op(isl_pkg::MODE_APPEND, 32'h1234_5678, 8'd0);
    send_op(isl_pkg::MODE_INSERT, 32'hCAFE_BABE, 8'd0);
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd0);
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd1);
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd2);
    // float kind sees the old wide entries whole
    write_kind(isl_pkg::KIND_FLOAT);
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd2);
    send_op(isl_pkg::MODE_READ,   32'h0,         8'd0);

    write_kind(isl_pkg::KIND_INT);
    for (n = 0; n < 120; n++) random_op(55, 50);

    // fill to capacity with no idling, then hammer the full list
    write_kind(isl_pkg::KIND_BYTE);
    steady = 1'b1;
    extra = 0;
    for (n = 0; n < 500 && extra < 25; n++) begin
      random_op(85, 50);
      if (sb.held >= LIST_DEPTH) extra++;
    end
    steady = 1'b0;

    // drain to empty
    write_kind(isl_pkg::KIND_FLOAT);
    extra = 0;
    for (n = 0; n < 500 && extra < 20; n++) begin
      random_op(5, 15);
      if (sb.held == 0) extra++;
    end

    write_kind(isl_pkg::KIND_SPARE);
    for (n = 0; n < 120; n++) random_op(50, 50);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    sb.flush_check();
    if (sb.err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
